[rtl/core/arf_pkg.sv]
// Package for the register-file ALU executor.
// Holds the opcode codes, the instruction layout and the register file sizes.
// No dependencies.
`timescale 1ns / 1ps

package arf_pkg;

    localparam int unsigned DataW  = 16;
    localparam int unsigned RegN   = 16;
    localparam int unsigned RegIdxW = 4;

    typedef enum logic [3:0] {
        OP_MOV  = 4'h0,
        OP_ADD  = 4'h1,
        OP_SUB  = 4'h2,
        OP_AND  = 4'h3,
        OP_OR   = 4'h4,
        OP_XOR  = 4'h5,
        OP_SLL  = 4'h6,
        OP_SRL  = 4'h7,
        OP_SRA  = 4'h8,
        OP_ADDI = 4'h9,
        OP_ANDI = 4'hA,
        OP_ORI  = 4'hB,
        OP_XORI = 4'hC,
        OP_SLLI = 4'hD,
        OP_SRLI = 4'hE,
        OP_SRAI = 4'hF
    } alu_op_t;

    typedef logic [RegIdxW-1:0] reg_idx_t;
    typedef logic [DataW-1:0]   data_t;

    typedef struct packed {
        alu_op_t  op;
        reg_idx_t dest;
        reg_idx_t src1;
        reg_idx_t src2;   // second source, immediate or shift amount
    } instr_t;

endpackage

[rtl/core/arf_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// Read is enabled by re; the read data hold while re is low. No dependencies.
`timescale 1ns / 1ps

module arf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[rtl/core/arf_alu.sv]
// ALU of the register-file executor: one operation on two operands.
// Depends on arf_pkg for opcodes and data types.
`timescale 1ns / 1ps

module arf_alu
    import arf_pkg::*;
(
    input  alu_op_t          op,
    input  data_t            opnd_a,
    input  data_t            opnd_b,
    input  logic [3:0]       raw,
    output data_t            result
);

    data_t      imm;
    logic [3:0] amt_reg_form;

    assign imm          = {{(DataW-4){raw[3]}}, raw};
    assign amt_reg_form = opnd_b[3:0];

    always_comb begin
        case (op)
            OP_MOV:  result = opnd_a;
            OP_ADD:  result = opnd_a + opnd_b;
            OP_SUB:  result = opnd_a - opnd_b;
            OP_AND:  result = opnd_a & opnd_b;
            OP_OR:   result = opnd_a | opnd_b;
            OP_XOR:  result = opnd_a ^ opnd_b;
            OP_SLL:  result = opnd_a << amt_reg_form;
            OP_SRL:  result = opnd_a >> amt_reg_form;
            OP_SRA:  result = data_t'($signed(opnd_a) >>> amt_reg_form);
            OP_ADDI: result = opnd_a + imm;
            OP_ANDI: result = opnd_a & imm;
            OP_ORI:  result = opnd_a | imm;
            OP_XORI: result = opnd_a ^ imm;
            OP_SLLI: result = opnd_a << raw;
            OP_SRLI: result = opnd_a >> raw;
            default: result = data_t'($signed(opnd_a) >>> raw);   // arithmetic shift by immediate
        endcase
    end

endmodule

[rtl/core/alu_register_file_executor_top.sv]
// A result reaches m_* via the execute-stage registers and then the result register.
// Throughput: one instruction per cycle unless m_ready stalls; the register read is
// issued at the input transfer; ALU and register write happen as it leaves execute.
// Reset (aresetn low, synchronous) empties both stages and clears the per-register
// valid bits, so every register reads zero at once; no clearing pass is needed.
// Depends on arf_pkg, arf_ram and arf_alu.
`timescale 1ns / 1ps

module alu_register_file_executor_top
    import arf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // instruction channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_instr_word,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_dest_index,
    output logic [15:0]          m_written_value
);

    // ---------------------------------------------------------------
    // Handshake control
    // ---------------------------------------------------------------
    logic     s1_valid_reg;
    instr_t   s1_instr_reg;
    logic     m_valid_reg;
    reg_idx_t m_dest_index_reg;
    data_t    m_written_value_reg;

    logic     out_free;
    logic     s1_advance;
    logic     s_xfer;
    instr_t   in_instr;

    assign in_instr   = instr_t'(s_instr_word);
    // output register can take a result when empty or being drained
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    // take a new instruction whenever the execute stage is empty or moving on
    assign s_ready    = !s1_valid_reg || out_free;
    assign s_xfer     = s_valid && s_ready;

    // ---------------------------------------------------------------
    // Register file: RAM for data, flops for "ever written" bits.
    // Register 0 is never written, so its valid bit stays low and it reads zero.
    // ---------------------------------------------------------------
    logic [RegN-1:0] ent_valid_reg;
    data_t           rd_a;
    data_t           rd_b;
    logic            wr_en;
    reg_idx_t        wr_addr;
    data_t           alu_res;

    assign wr_en   = s1_advance && (s1_instr_reg.dest != '0);
    assign wr_addr = s1_instr_reg.dest;

    arf_ram #(
        .WIDTH (DataW),
        .DEPTH (RegN)
    ) u_regfile (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (alu_res),
        .re      (s_xfer),
        .raddr_a (in_instr.src1),
        .raddr_b (in_instr.src2),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (wr_en) begin
            ent_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Operand capture at the input transfer.
    // The RAM read sees the old contents when the instruction ahead writes
    // on the same edge, so record a bypass of that write.
    // ---------------------------------------------------------------
    logic  live_a_reg, live_b_reg;
    logic  hit_a_reg, hit_b_reg;
    data_t byp_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_instr_reg <= in_instr;
            live_a_reg   <= ent_valid_reg[in_instr.src1];
            live_b_reg   <= ent_valid_reg[in_instr.src2];
            hit_a_reg    <= wr_en && (wr_addr == in_instr.src1);
            hit_b_reg    <= wr_en && (wr_addr == in_instr.src2);
            byp_data_reg <= alu_res;
        end
    end

    // ---------------------------------------------------------------
    // Execute: pick operands, run the ALU
    // ---------------------------------------------------------------
    data_t opnd_a, opnd_b;

    always_comb begin
        if (hit_a_reg) begin
            opnd_a = byp_data_reg;
        end else if (live_a_reg) begin
            opnd_a = rd_a;
        end else begin
            opnd_a = '0;
        end
        if (hit_b_reg) begin
            opnd_b = byp_data_reg;
        end else if (live_b_reg) begin
            opnd_b = rd_b;
        end else begin
            opnd_b = '0;
        end
    end

    arf_alu u_alu (
        .op     (s1_instr_reg.op),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .raw    (s1_instr_reg.src2),
        .result (alu_res)
    );

    // ---------------------------------------------------------------
    // Result register: hold while stalled, drop valid once transferred
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_dest_index_reg    <= s1_instr_reg.dest;
            // writes to register 0 are dropped; report zero
            m_written_value_reg <= (s1_instr_reg.dest == '0) ? '0 : alu_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_dest_index    = m_dest_index_reg;
    assign m_written_value = m_written_value_reg;

`ifndef ASSERT_OFF
    // register 0 is never marked written
    a_reg0_never_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !ent_valid_reg[0])
        else $error("register 0 marked as written");

    // a reported write to register 0 always carries zero
    a_dest0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_dest_index_reg == '0) |-> (m_written_value_reg == '0))
        else $error("nonzero value reported for register 0");

    // a stalled execute stage keeps its RAM read data
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> $stable(rd_a) && $stable(rd_b))
        else $error("register read data changed under a stalled instruction");

    // a register write marks its entry valid
    a_wr_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> ent_valid_reg[$past(wr_addr)])
        else $error("written register not marked valid");
`endif

endmodule

[bench/arf_scoreboard_pkg.sv]
// Scoreboard for the register-file ALU executor bench.
// Keeps a shadow register file, predicts each write and checks the result stream.
// Depends on arf_pkg.
`timescale 1ns / 1ps

package arf_scoreboard_pkg;
    import arf_pkg::*;

    typedef struct packed {
        reg_idx_t dest;
        data_t    value;
    } reg_write_t;

    class arf_scoreboard;
        data_t      shadow_regs[RegN];
        reg_write_t pending_writes[$];
        int         instr_count;
        int         result_count;
        int         error_count;

        function new();
            foreach (shadow_regs[i]) shadow_regs[i] = '0;
            instr_count  = 0;
            result_count = 0;
            error_count  = 0;
        endfunction

        function data_t read_shadow(reg_idx_t idx);
            return (idx == '0) ? data_t'(0) : shadow_regs[idx];
        endfunction

        // Execute one instruction on the shadow file and return the value it leaves.
        function data_t predict_write(logic [15:0] word);
            instr_t ins;
            data_t  a;
            data_t  b;
            data_t  imm;
            data_t  r;
            ins = instr_t'(word);
            a   = read_shadow(ins.src1);
            b   = read_shadow(ins.src2);
            imm = {{12{ins.src2[3]}}, ins.src2};
            case (ins.op)
                OP_MOV:  r = a;
                OP_ADD:  r = a + b;
                OP_SUB:  r = a - b;
                OP_AND:  r = a & b;
                OP_OR:   r = a | b;
                OP_XOR:  r = a ^ b;
                OP_SLL:  r = a << b[3:0];
                OP_SRL:  r = a >> b[3:0];
                OP_SRA:  r = data_t'($signed(a) >>> b[3:0]);
                OP_ADDI: r = a + imm;
                OP_ANDI: r = a & imm;
                OP_ORI:  r = a | imm;
                OP_XORI: r = a ^ imm;
                OP_SLLI: r = a << ins.src2;
                OP_SRLI: r = a >> ins.src2;
                default: r = data_t'($signed(a) >>> ins.src2);
            endcase
            if (ins.dest != '0) shadow_regs[ins.dest] = r;
            return read_shadow(ins.dest);
        endfunction

        function void note_instr(logic [15:0] word);
            reg_write_t w;
            w.value = predict_write(word);
            w.dest  = word[11:8];
            pending_writes.push_back(w);
            instr_count++;
        endfunction

        function void check_result(reg_idx_t dest, data_t value);
            reg_write_t w;
            result_count++;
            if (pending_writes.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result dest %0d value %h with no instruction pending",
                             $time, dest, value);
                return;
            end
            w = pending_writes.pop_front();
            if (w.dest !== dest || w.value !== value) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result %0d expected dest %0d value %h, got dest %0d value %h",
                             $time, result_count, w.dest, w.value, dest, value);
            end
        endfunction
    endclass

endpackage

[bench/tb_alu_register_file_executor_top.sv]
// Bench top for alu_register_file_executor_top: directed corner instructions, then
// random instruction streams under four idle/stall mixes, checked by the scoreboard.
// Depends on arf_pkg, arf_scoreboard_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_alu_register_file_executor_top;
    import arf_pkg::*;
    import arf_scoreboard_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int PhaseItems   = 212;
    localparam int SettleCycles = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_instr_word;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_dest_index;
    logic [15:0] m_written_value;

    int src_idle_pct;
    int sink_stall_pct;
    int cycle_count;

    arf_scoreboard sb;

    alu_register_file_executor_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instr_word    (s_instr_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_index    (m_dest_index),
        .m_written_value (m_written_value)
    );

    // Free-running clock, 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: count cycles and end the run if the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, sb.pending_writes.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Monitor both channels at the rising edge. Inputs move only on the falling
    // edge, so the values seen here are the ones the block saw at this edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_instr(s_instr_word);
            if (m_valid && m_ready) sb.check_result(m_dest_index, m_written_value);
        end
    end

    // Receiver: drop ready at random according to the current stall rate.
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [15:0] encode(alu_op_t op, reg_idx_t d, reg_idx_t s1,
                                           logic [3:0] s2);
        return {op, d, s1, s2};
    endfunction

    // Present one instruction and hold it until the transfer happens.
    // Valid stays high on return so back-to-back transfers need no gap.
    task automatic send_instr(input logic [15:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_instr_word <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold off the sender until every predicted write has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (PhaseItems) send_instr(16'($urandom_range(65535)));
        drain_results();
    endtask

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_instr_word   = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        // Hold reset, then release it on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: build extreme operands, then hit every opcode once or more.
        send_instr(encode(OP_ADDI, 4'd1, 4'd0, 4'hF));   // r1 = all ones via negative imm
        send_instr(encode(OP_ADDI, 4'd2, 4'd0, 4'h7));   // r2 = largest positive imm
        send_instr(encode(OP_SLLI, 4'd3, 4'd1, 4'hF));   // r3 = sign bit only
        send_instr(encode(OP_SRLI, 4'd4, 4'd1, 4'h1));   // r4 = largest positive value
        send_instr(encode(OP_ADD,  4'd5, 4'd1, 4'd2));   // sum wraps
        send_instr(encode(OP_SUB,  4'd6, 4'd0, 4'd2));   // difference wraps below zero
        send_instr(encode(OP_AND,  4'd7, 4'd1, 4'd4));
        send_instr(encode(OP_OR,   4'd8, 4'd3, 4'd2));
        send_instr(encode(OP_XOR,  4'd9, 4'd1, 4'd3));
        send_instr(encode(OP_SLL,  4'd10, 4'd4, 4'd1));  // amount taken from low 4 bits only
        send_instr(encode(OP_SRL,  4'd11, 4'd3, 4'd2));
        send_instr(encode(OP_SRA,  4'd12, 4'd3, 4'd1));  // full-width sign fill
        send_instr(encode(OP_SRA,  4'd13, 4'd4, 4'd2));  // positive operand, zero fill
        send_instr(encode(OP_ANDI, 4'd14, 4'd1, 4'h8));  // most negative imm
        send_instr(encode(OP_ORI,  4'd15, 4'd0, 4'h8));
        send_instr(encode(OP_XORI, 4'd5, 4'd1, 4'h7));
        send_instr(encode(OP_SRAI, 4'd6, 4'd3, 4'hF));
        send_instr(encode(OP_SRAI, 4'd7, 4'd3, 4'h0));   // zero shift
        send_instr(encode(OP_MOV,  4'd8, 4'd1, 4'h0));
        send_instr(encode(OP_MOV,  4'd0, 4'd1, 4'h0));   // write to register zero is dropped
        send_instr(encode(OP_ADD,  4'd9, 4'd0, 4'd0));   // zero sources read zero
        send_instr(encode(OP_ADDI, 4'd0, 4'd1, 4'h1));
        send_instr(encode(OP_SLLI, 4'd10, 4'd1, 4'h0));
        send_instr(encode(OP_SRLI, 4'd11, 4'd1, 4'hF));
        send_instr(encode(OP_MOV,  4'd12, 4'd0, 4'h0));
        drain_results();

        // Random streams under each idle/stall mix; drain between phases.
        run_random_phase(0, 0);
        run_random_phase(66, 0);
        run_random_phase(0, 66);
        run_random_phase(37, 37);

        // Let any stray output show up before the verdict.
        repeat (SettleCycles) @(posedge aclk);

        if (sb.pending_writes.size() != 0) begin
            sb.error_count++;
            $display("%0d predicted writes never came back", sb.pending_writes.size());
        end
        $display("Ran %0d instructions (directed corners plus four traffic mixes), %0d results",
                 sb.instr_count, sb.result_count);
        $display("checked against the shadow register file; %0d mismatches", sb.error_count);
        if (sb.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
